// File: src/vas_pkg.sv
`timescale 1ns / 1ps

package vas_pkg;

  // Event kinds as carried on the input side
  typedef enum logic [1:0] {
    EV_NOTE_ON  = 2'd0,
    EV_NOTE_OFF = 2'd1,
    EV_RESET    = 2'd2,
    EV_OTHER    = 2'd3
  } event_kind_t;

  // Load pressure levels
  typedef enum logic [1:0] {
    PR_NORMAL = 2'd0,
    PR_SOFT   = 2'd1,
    PR_HARD   = 2'd2,
    PR_PANIC  = 2'd3
  } pressure_t;

  // Actions reported on the output side
  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_SPAWN   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_RESET   = 2'd3
  } action_t;

  // Configuration register indexes
  localparam logic [1:0] REG_STRONG_THR = 2'd0;
  localparam logic [1:0] REG_MEDIUM_THR = 2'd1;
  localparam logic [1:0] REG_PANIC_THR  = 2'd2;
  localparam logic [1:0] REG_IDLE_LIMIT = 2'd3;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 16;

  // Field widths
  localparam int ThrW      = 9;
  localparam int VoiceW    = 16;
  localparam int VelW      = 7;
  localparam int ScoreW    = 9;
  localparam int OutCntW   = 32;

  // Register reset values
  localparam logic [ThrW-1:0]   STRONG_THR_RST = 9'd208;
  localparam logic [ThrW-1:0]   MEDIUM_THR_RST = 9'd128;
  localparam logic [ThrW-1:0]   PANIC_THR_RST  = 9'd96;
  localparam logic [VoiceW-1:0] IDLE_LIMIT_RST = 16'd32;

  // Score constants
  localparam logic [ScoreW-1:0] SCORE_NOTE_OFF  = 9'd32;
  localparam logic [ScoreW-1:0] SCORE_RESET     = 9'd255;
  localparam logic [ScoreW-1:0] BONUS_IDLE      = 9'd16;
  localparam logic [ScoreW-1:0] BONUS_SOFT      = 9'd8;
  localparam logic [ScoreW-1:0] BONUS_HARD      = 9'd16;
  localparam logic [ScoreW-1:0] BONUS_PANIC     = 9'd24;
  localparam logic [ScoreW-1:0] SCORE_MAX       = 9'd295;

  // Window counters, by slot
  localparam int NumCnt          = 8;
  localparam int CNT_EXACT       = 0;
  localparam int CNT_PROTECTED   = 1;
  localparam int CNT_GROUPED_OBS = 2;
  localparam int CNT_GROUPED_ONLY = 3;
  localparam int CNT_DENSITY_OBS = 4;
  localparam int CNT_DENSITY_ONLY = 5;
  localparam int CNT_PANIC       = 6;
  localparam int CNT_RESET       = 7;

  localparam int CounterBitsDef  = 32;

  // Stream packing
  localparam int InUserW  = 3;
  localparam int InDataW  = 32;
  localparam int OutUserW = 4;
  localparam int OutDataW = 272;

  // Decision thresholds
  typedef struct packed {
    logic [ThrW-1:0]   strong_thr;
    logic [ThrW-1:0]   medium_thr;
    logic [ThrW-1:0]   panic_thr;
    logic [VoiceW-1:0] idle_limit;
  } thr_cfg_t;

  // One registered event
  typedef struct packed {
    logic              window_start;
    event_kind_t       event_kind;
    logic [VelW-1:0]   note_velocity;
    logic [VoiceW-1:0] active_voices;
    pressure_t         pressure;
  } event_t;

  // Decision for one event, with the counters it bumps
  typedef struct packed {
    action_t             action_kind;
    logic                observe_grouped;
    logic                observe_density;
    logic [ScoreW-1:0]   importance_score;
    logic [NumCnt-1:0]   inc;
  } decision_t;

endpackage

// File: src/vas_decide.sv
`timescale 1ns / 1ps

module vas_decide
  import vas_pkg::*;
(
  input  event_t    ev,
  input  thr_cfg_t  cfg,
  output decision_t dec
);

  logic [ScoreW-1:0] base;
  logic [ScoreW-1:0] idle_bonus;
  logic [ScoreW-1:0] pres_bonus;
  logic [ScoreW-1:0] score;
  logic [ThrW-1:0]   grp_thr;
  logic              strong_hit;

  // Base score by kind
  always_comb begin
    case (ev.event_kind)
      EV_NOTE_ON:  base = {1'b0, ev.note_velocity, 1'b0};
      EV_NOTE_OFF: base = SCORE_NOTE_OFF;
      EV_RESET:    base = SCORE_RESET;
      default:     base = '0;
    endcase
  end

  // Bonuses for idle voices and for pressure
  always_comb begin
    case (ev.pressure)
      PR_SOFT:  pres_bonus = BONUS_SOFT;
      PR_HARD:  pres_bonus = BONUS_HARD;
      PR_PANIC: pres_bonus = BONUS_PANIC;
      default:  pres_bonus = '0;
    endcase
  end

  assign idle_bonus = (ev.active_voices < cfg.idle_limit) ? BONUS_IDLE : '0;
  assign score      = base + idle_bonus + pres_bonus;
  assign strong_hit = (score >= cfg.strong_thr);
  assign grp_thr    = (ev.pressure == PR_PANIC) ? cfg.panic_thr : cfg.medium_thr;

  // Action, observation flags and counter bumps
  always_comb begin
    dec                 = '0;
    dec.action_kind     = ACT_NONE;
    if (!ev.window_start) begin
      dec.importance_score = score;
      case (ev.event_kind)
        EV_NOTE_ON: begin
          dec.inc[CNT_PANIC] = (ev.pressure == PR_PANIC);
          if (ev.pressure inside {PR_NORMAL, PR_SOFT} || strong_hit) begin
            dec.action_kind        = ACT_SPAWN;
            dec.inc[CNT_EXACT]     = 1'b1;
            dec.inc[CNT_PROTECTED] = 1'b1;
            // soft pressure: weak attacks are also watched as a group
            if (ev.pressure == PR_SOFT && score < cfg.medium_thr) begin
              dec.observe_grouped      = 1'b1;
              dec.inc[CNT_GROUPED_OBS] = 1'b1;
            end
          end else if (score >= grp_thr) begin
            dec.observe_grouped       = 1'b1;
            dec.inc[CNT_GROUPED_OBS]  = 1'b1;
            dec.inc[CNT_GROUPED_ONLY] = 1'b1;
          end else begin
            dec.observe_density       = 1'b1;
            dec.inc[CNT_DENSITY_OBS]  = 1'b1;
            dec.inc[CNT_DENSITY_ONLY] = 1'b1;
          end
        end
        EV_NOTE_OFF: begin
          dec.action_kind    = ACT_RELEASE;
          dec.inc[CNT_EXACT] = 1'b1;
        end
        EV_RESET: begin
          dec.action_kind    = ACT_RESET;
          dec.inc[CNT_RESET] = 1'b1;
        end
        default: begin
          dec.action_kind = ACT_NONE;
        end
      endcase
    end
  end

endmodule

// File: src/voice_admission_scorer.sv
`timescale 1ns / 1ps
// Path: an accepted request goes through the input register, then the result
// register with the window counters, to its result on the master side.
// Throughput: one request per cycle; while a result waits on the master side
// the input register takes at most one more request, then holds tready low.
// Reset (rst, synchronous): thresholds return to 208/128/96/32, all window
// counters clear, both stages empty.

module voice_admission_scorer
  import vas_pkg::*;
#(
  parameter int COUNTER_BITS = CounterBitsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  // event stream in
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [6:0] note_velocity, [22:7] active_voices, [24:23] pressure, rest zero
  input  logic [InDataW-1:0]   s_axis_tdata,
  // [0] window_start, [2:1] event_kind
  input  logic [InUserW-1:0]   s_axis_tuser,
  // decision stream out
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [8:0] importance_score, then 32 bits each: exact_count, protected_count,
  // grouped_obs_count, grouped_only_count, density_obs_count,
  // density_only_count, panic_count, reset_count; [271:265] zero
  output logic [OutDataW-1:0]  m_axis_tdata,
  // [1:0] action_kind, [2] observe_grouped, [3] observe_density
  output logic [OutUserW-1:0]  m_axis_tuser
);

  thr_cfg_t cfg;

  event_t    ev;
  logic      ev_valid;
  logic      advance;
  decision_t dec;

  logic [COUNTER_BITS-1:0] cnt      [NumCnt];
  logic [COUNTER_BITS-1:0] cnt_next [NumCnt];

  logic                out_valid;
  action_t             out_action;
  logic                out_grouped;
  logic                out_density;
  logic [ScoreW-1:0]   out_score;
  logic [OutCntW-1:0]  out_cnt [NumCnt];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strong_thr <= STRONG_THR_RST;
      cfg.medium_thr <= MEDIUM_THR_RST;
      cfg.panic_thr  <= PANIC_THR_RST;
      cfg.idle_limit <= IDLE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STRONG_THR: cfg.strong_thr <= cfg_data[ThrW-1:0];
        REG_MEDIUM_THR: cfg.medium_thr <= cfg_data[ThrW-1:0];
        REG_PANIC_THR:  cfg.panic_thr  <= cfg_data[ThrW-1:0];
        REG_IDLE_LIMIT: cfg.idle_limit <= cfg_data[VoiceW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input stage moves on when the result register is free
  assign advance       = ev_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !ev_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (s_axis_tready) begin
      ev_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      ev.window_start  <= s_axis_tuser[0];
      ev.event_kind    <= event_kind_t'(s_axis_tuser[2:1]);
      ev.note_velocity <= s_axis_tdata[6:0];
      ev.active_voices <= s_axis_tdata[22:7];
      ev.pressure      <= pressure_t'(s_axis_tdata[24:23]);
    end
  end

  vas_decide u_decide (
    .ev  (ev),
    .cfg (cfg),
    .dec (dec)
  );

  // Counter update: clear on window start, otherwise bump the flagged ones
  always_comb begin
    for (int i = 0; i < NumCnt; i++) begin
      if (ev.window_start) begin
        cnt_next[i] = '0;
      end else begin
        cnt_next[i] = cnt[i] + COUNTER_BITS'(dec.inc[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumCnt; i++) begin
        cnt[i] <= '0;
      end
    end else if (advance) begin
      for (int i = 0; i < NumCnt; i++) begin
        cnt[i] <= cnt_next[i];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_action  <= dec.action_kind;
      out_grouped <= dec.observe_grouped;
      out_density <= dec.observe_density;
      out_score   <= dec.importance_score;
      for (int i = 0; i < NumCnt; i++) begin
        out_cnt[i] <= OutCntW'(cnt_next[i]);
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = {out_density, out_grouped, out_action};
  assign m_axis_tdata  = {7'd0,
                          out_cnt[CNT_RESET], out_cnt[CNT_PANIC],
                          out_cnt[CNT_DENSITY_ONLY], out_cnt[CNT_DENSITY_OBS],
                          out_cnt[CNT_GROUPED_ONLY], out_cnt[CNT_GROUPED_OBS],
                          out_cnt[CNT_PROTECTED], out_cnt[CNT_EXACT],
                          out_score};

  // A result never asks for both kinds of observation
  a_obs_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_grouped && out_density))
    else $error("grouped and density observation both set");

  // A spawned voice is never only a density observation
  a_spawn_no_density: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_action == ACT_SPAWN) |-> !out_density)
    else $error("spawn with density observation");

  // Score stays within its range
  a_score_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_score <= SCORE_MAX))
    else $error("score out of range");

  // A window start reports cleared counters and a plain result
  a_window_clear: assert property (@(posedge clk) disable iff (rst)
    (advance && ev.window_start) |=>
      (out_cnt[CNT_EXACT] == '0 && out_cnt[CNT_RESET] == '0 &&
       out_cnt[CNT_PANIC] == '0 && out_score == '0 && out_action == ACT_NONE))
    else $error("window start did not clear");

  // A held input item is not dropped while the result side stalls
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (ev_valid && !advance) |=> ev_valid)
    else $error("input stage lost a request");

endmodule

// File: verif/vas_decision_checker.sv
`timescale 1ns / 1ps

// Watches the config port and both streams, predicts each decision and
// compares it with what comes out of the master side.
module vas_decision_checker
  import vas_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,
  input  logic [InUserW-1:0]   s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [OutDataW-1:0]  m_axis_tdata,
  input  logic [OutUserW-1:0]  m_axis_tuser,
  output int                   mismatches,
  output int                   outstanding
);

  // score terms
  localparam logic [ScoreW-1:0] NOTE_OFF_BASE = 9'd32;
  localparam logic [ScoreW-1:0] RESET_BASE    = 9'd255;
  localparam logic [ScoreW-1:0] IDLE_BONUS    = 9'd16;
  localparam logic [ScoreW-1:0] SOFT_BONUS    = 9'd8;
  localparam logic [ScoreW-1:0] HARD_BONUS    = 9'd16;
  localparam logic [ScoreW-1:0] PANIC_BONUS   = 9'd24;

  typedef struct packed {
    action_t                         action_kind;
    logic                            observe_grouped;
    logic                            observe_density;
    logic [ScoreW-1:0]               importance_score;
    logic [NumCnt-1:0][OutCntW-1:0]  counts;
  } decision_rec_t;

  thr_cfg_t                        thresholds;
  logic [NumCnt-1:0][OutCntW-1:0]  window_tally;
  decision_rec_t                   decisions_due[$];
  int                              err_count = 0;
  string                           count_name[NumCnt] = '{
    "exact_count", "protected_count", "grouped_obs_count", "grouped_only_count",
    "density_obs_count", "density_only_count", "panic_count", "reset_count"};

  // Score one accepted request, bump the window tallies, queue the decision
  task automatic score_event(input event_t ev);
    decision_rec_t     d;
    logic [ScoreW-1:0] group_thr;
    logic              strong_hit;
    d = '0;
    if (ev.window_start) begin
      window_tally = '0;
    end else begin
      case (ev.event_kind)
        EV_NOTE_ON:  d.importance_score = {1'b0, ev.note_velocity, 1'b0};
        EV_NOTE_OFF: d.importance_score = NOTE_OFF_BASE;
        EV_RESET:    d.importance_score = RESET_BASE;
        default:     d.importance_score = '0;
      endcase
      if (ev.active_voices < thresholds.idle_limit) begin
        d.importance_score += IDLE_BONUS;
      end
      case (ev.pressure)
        PR_SOFT:  d.importance_score += SOFT_BONUS;
        PR_HARD:  d.importance_score += HARD_BONUS;
        PR_PANIC: d.importance_score += PANIC_BONUS;
        default:  ;
      endcase

      if (ev.event_kind == EV_NOTE_ON) begin
        strong_hit = d.importance_score >= thresholds.strong_thr;
        group_thr  = (ev.pressure == PR_PANIC) ? thresholds.panic_thr : thresholds.medium_thr;
        if (ev.pressure == PR_PANIC) begin
          window_tally[CNT_PANIC] += 1;
        end
        if (ev.pressure == PR_NORMAL || ev.pressure == PR_SOFT || strong_hit) begin
          d.action_kind = ACT_SPAWN;
          window_tally[CNT_EXACT]     += 1;
          window_tally[CNT_PROTECTED] += 1;
          // soft pressure with a weak score is also watched as grouped
          if (ev.pressure == PR_SOFT && d.importance_score < thresholds.medium_thr) begin
            d.observe_grouped = 1'b1;
            window_tally[CNT_GROUPED_OBS] += 1;
          end
        end else if (d.importance_score >= group_thr) begin
          d.observe_grouped = 1'b1;
          window_tally[CNT_GROUPED_OBS]  += 1;
          window_tally[CNT_GROUPED_ONLY] += 1;
        end else begin
          d.observe_density = 1'b1;
          window_tally[CNT_DENSITY_OBS]  += 1;
          window_tally[CNT_DENSITY_ONLY] += 1;
        end
      end else if (ev.event_kind == EV_NOTE_OFF) begin
        d.action_kind = ACT_RELEASE;
        window_tally[CNT_EXACT] += 1;
      end else if (ev.event_kind == EV_RESET) begin
        d.action_kind = ACT_RESET;
        window_tally[CNT_RESET] += 1;
      end
    end
    d.counts = window_tally;
    decisions_due.push_back(d);
  endtask

  task automatic flag_field(input string name, input logic [OutCntW-1:0] want,
                            input logic [OutCntW-1:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    decision_rec_t want;
    event_t        ev;
    if (rst) begin
      thresholds.strong_thr = 9'd208;
      thresholds.medium_thr = 9'd128;
      thresholds.panic_thr  = 9'd96;
      thresholds.idle_limit = 16'd32;
      window_tally          = '0;
      decisions_due.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_STRONG_THR: thresholds.strong_thr = cfg_data[ThrW-1:0];
          REG_MEDIUM_THR: thresholds.medium_thr = cfg_data[ThrW-1:0];
          REG_PANIC_THR:  thresholds.panic_thr  = cfg_data[ThrW-1:0];
          REG_IDLE_LIMIT: thresholds.idle_limit = cfg_data[VoiceW-1:0];
          default: ;
        endcase
      end

      // result side first, so a result can never match a request of this edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (decisions_due.size() == 0) begin
          err_count++;
          $display("%0t ns: result with none expected, tuser %0h score %0d",
                   $time, m_axis_tuser, m_axis_tdata[ScoreW-1:0]);
        end else begin
          want = decisions_due.pop_front();
          flag_field("action_kind", 32'(want.action_kind), 32'(m_axis_tuser[1:0]));
          flag_field("observe_grouped", 32'(want.observe_grouped), 32'(m_axis_tuser[2]));
          flag_field("observe_density", 32'(want.observe_density), 32'(m_axis_tuser[3]));
          flag_field("importance_score", 32'(want.importance_score),
                     32'(m_axis_tdata[ScoreW-1:0]));
          for (int i = 0; i < NumCnt; i++) begin
            flag_field(count_name[i], want.counts[i],
                       m_axis_tdata[ScoreW + OutCntW*i +: OutCntW]);
          end
        end
      end

      // request side
      if (s_axis_tvalid && s_axis_tready) begin
        ev.window_start  = s_axis_tuser[0];
        ev.event_kind    = event_kind_t'(s_axis_tuser[2:1]);
        ev.note_velocity = s_axis_tdata[6:0];
        ev.active_voices = s_axis_tdata[22:7];
        ev.pressure      = pressure_t'(s_axis_tdata[24:23]);
        score_event(ev);
      end
    end
    mismatches  <= err_count;
    outstanding <= decisions_due.size();
  end

endmodule

// File: verif/voice_admission_scorer_test.sv
`timescale 1ns / 1ps

module voice_admission_scorer_test;
  import vas_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BLOCKS  = 8;
  localparam int BLOCK_ITEMS    = 115;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 cfg_we        = 1'b0;
  logic [CfgIndexW-1:0] cfg_index     = '0;
  logic [CfgDataW-1:0]  cfg_data      = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic [InUserW-1:0]   s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic [OutUserW-1:0]  m_axis_tuser;

  int                   mismatches;
  int                   outstanding;
  int                   send_idle_pct  = 0;
  int                   recv_stall_pct = 0;
  int                   quiet_cycles   = 0;
  logic [VoiceW-1:0]    idle_limit_now = 16'd32;

  always #5 clk = ~clk;

  voice_admission_scorer DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  vas_decision_checker decision_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // receiver backpressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: cycles without any request, result or register write
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // one request, with random idle cycles ahead of it
  task automatic push_event(input logic ws, input event_kind_t kind,
                            input logic [VelW-1:0] vel, input logic [VoiceW-1:0] voices,
                            input pressure_t pres);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, pres, voices, vel};
    s_axis_tuser  <= {kind, ws};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // stop sending and wait until every decision is back, plus the pipe depth
  task automatic drain_decisions();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // all four registers, upper data bits of the 9-bit ones filled with noise
  task automatic write_thresholds(input logic [ThrW-1:0] strong_val,
                                  input logic [ThrW-1:0] medium_val,
                                  input logic [ThrW-1:0] panic_val,
                                  input logic [VoiceW-1:0] idle_val);
    drain_decisions();
    cfg_we    <= 1'b1;
    cfg_index <= REG_STRONG_THR;
    cfg_data  <= {7'($urandom_range(127)), strong_val};
    @(posedge clk);
    cfg_index <= REG_MEDIUM_THR;
    cfg_data  <= {7'($urandom_range(127)), medium_val};
    @(posedge clk);
    cfg_index <= REG_PANIC_THR;
    cfg_data  <= {7'($urandom_range(127)), panic_val};
    @(posedge clk);
    cfg_index <= REG_IDLE_LIMIT;
    cfg_data  <= idle_val;
    @(posedge clk);
    cfg_we         <= 1'b0;
    idle_limit_now  = idle_val;
  endtask

  // random event: mostly note-ons, voices often near the idle limit
  task automatic send_random_event();
    logic              ws;
    event_kind_t       kind;
    logic [VelW-1:0]   vel;
    logic [VoiceW-1:0] voices;
    int                pick;
    ws   = ($urandom_range(99) < 3);
    pick = $urandom_range(99);
    if (pick < 55)      kind = EV_NOTE_ON;
    else if (pick < 70) kind = EV_NOTE_OFF;
    else if (pick < 85) kind = EV_RESET;
    else                kind = EV_OTHER;
    if ($urandom_range(9) == 0) vel = $urandom_range(1) ? 7'd127 : 7'd0;
    else                        vel = 7'($urandom_range(127));
    pick = $urandom_range(99);
    if (pick < 40)      voices = idle_limit_now + 16'($urandom_range(2)) - 16'd1;
    else if (pick < 70) voices = 16'($urandom_range(255));
    else                voices = 16'($urandom);
    push_event(ws, kind, vel, voices, pressure_t'($urandom_range(3)));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset thresholds 208/128/96/32
    push_event(1'b0, EV_NOTE_ON,  7'd0,   16'd0,     PR_NORMAL);
    push_event(1'b0, EV_NOTE_ON,  7'd127, 16'hFFFF,  PR_NORMAL);
    push_event(1'b0, EV_NOTE_ON,  7'd127, 16'd0,     PR_PANIC);
    push_event(1'b0, EV_NOTE_ON,  7'd127, 16'd0,     PR_SOFT);
    push_event(1'b0, EV_NOTE_ON,  7'd0,   16'hFFFF,  PR_HARD);
    push_event(1'b0, EV_NOTE_ON,  7'd0,   16'hFFFF,  PR_PANIC);
    // hard pressure: exactly on strong, just under, on medium, under medium
    push_event(1'b0, EV_NOTE_ON,  7'd96,  16'd100,   PR_HARD);
    push_event(1'b0, EV_NOTE_ON,  7'd95,  16'd100,   PR_HARD);
    push_event(1'b0, EV_NOTE_ON,  7'd56,  16'd100,   PR_HARD);
    push_event(1'b0, EV_NOTE_ON,  7'd55,  16'd100,   PR_HARD);
    // panic: on and under the panic group threshold
    push_event(1'b0, EV_NOTE_ON,  7'd36,  16'd100,   PR_PANIC);
    push_event(1'b0, EV_NOTE_ON,  7'd35,  16'd100,   PR_PANIC);
    // soft: grouped watch below medium, none at medium
    push_event(1'b0, EV_NOTE_ON,  7'd59,  16'd100,   PR_SOFT);
    push_event(1'b0, EV_NOTE_ON,  7'd60,  16'd100,   PR_SOFT);
    // idle bonus edge
    push_event(1'b0, EV_NOTE_ON,  7'd10,  16'd31,    PR_NORMAL);
    push_event(1'b0, EV_NOTE_ON,  7'd10,  16'd32,    PR_NORMAL);
    push_event(1'b0, EV_NOTE_OFF, 7'd77,  16'd0,     PR_NORMAL);
    push_event(1'b0, EV_NOTE_OFF, 7'd0,   16'hFFFF,  PR_PANIC);
    push_event(1'b0, EV_RESET,    7'd3,   16'd0,     PR_HARD);
    // highest possible score
    push_event(1'b0, EV_RESET,    7'd127, 16'd0,     PR_PANIC);
    push_event(1'b0, EV_OTHER,    7'd127, 16'd0,     PR_SOFT);
    push_event(1'b0, EV_OTHER,    7'd0,   16'hFFFF,  PR_NORMAL);
    // window start with junk in the other fields
    push_event(1'b1, EV_RESET,    7'd127, 16'd0,     PR_PANIC);
    push_event(1'b0, EV_NOTE_ON,  7'd64,  16'd5,     PR_HARD);
    push_event(1'b1, EV_NOTE_ON,  7'd0,   16'd0,     PR_NORMAL);

    // random blocks, each with thresholds written anew and one of four idle patterns
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      case (blk)
        0: write_thresholds(9'd0, 9'd0, 9'd0, 16'd0);
        1: write_thresholds(9'h1FF, 9'h1FF, 9'h1FF, 16'hFFFF);
        2: write_thresholds(9'd208, 9'd128, 9'd96, 16'd32);
        default: write_thresholds(9'($urandom_range(300)), 9'($urandom_range(300)),
                                  9'($urandom_range(300)),
                                  $urandom_range(1) ? 16'($urandom_range(400)) : 16'($urandom));
      endcase
      case (blk % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        // hold off mid-block until the pipe is empty
        if (blk == 6 && n == BLOCK_ITEMS / 2) drain_decisions();
        send_random_event();
      end
    end

    drain_decisions();
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
src/vas_pkg.sv
src/vas_decide.sv
src/voice_admission_scorer.sv
verif/vas_decision_checker.sv
verif/voice_admission_scorer_test.sv
